FILE: sv/ssqe_pkg.sv
// ---------------------------------------------------------------------------
// ssqe_pkg
// Shared codes, defaults and control/status structs for the SPI slave
// queued exchange block.
// ---------------------------------------------------------------------------
package ssqe_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 8;

  // action codes
  localparam logic [1:0] ACT_QUEUE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_EXCH  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TX_FULL  = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY = 2'd2;
  localparam logic [1:0] ST_EXCH     = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic append;
    logic keep;
    logic consume;
  } mark_ctrl_t;

  typedef struct packed {
    logic pending;
    logic oldest;
  } mark_stat_t;

endpackage

FILE: sv/ssqe_fifo.sv
// ---------------------------------------------------------------------------
// ssqe_fifo
// Byte FIFO with a registered head: head shows the oldest entry in the
// cycle after any push or pop.
// ---------------------------------------------------------------------------
module ssqe_fifo
  import ssqe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  input  logic [7:0] wdata,
  output logic [7:0] head,
  output fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] rd_pos;
  logic [AW-1:0] rd_pos_next;
  logic [AW-1:0] wr_pos;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FULL);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;

  always_comb begin
    rd_pos_next = rd_pos;
    if (do_pop) begin
      rd_pos_next = (rd_pos == LAST) ? '0 : rd_pos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos <= '0;
      wr_pos <= '0;
      fill   <= '0;
    end else begin
      rd_pos <= rd_pos_next;
      if (do_push) begin
        wr_pos <= (wr_pos == LAST) ? '0 : wr_pos + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  // storage and registered head read, bypassing a write to the new head
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_pos] <= wdata;
    end
    if (do_push && (wr_pos == rd_pos_next)) begin
      head <= wdata;
    end else begin
      head <= mem[rd_pos_next];
    end
  end

endmodule

FILE: sv/ssqe_marks.sv
// ---------------------------------------------------------------------------
// ssqe_marks
// Bit queue of keep/drop marks; bit 0 is the oldest, append at the count.
// ---------------------------------------------------------------------------
module ssqe_marks
  import ssqe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  mark_ctrl_t ctrl,
  output mark_stat_t stat
);

  // one mark per queued byte plus the one in the shift register
  localparam int MW = DEPTH + 1;
  localparam int CW = $clog2(MW + 1);
  localparam logic [CW-1:0] CMAX = CW'(MW);

  logic [MW-1:0] marks;
  logic [MW-1:0] marks_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign stat.pending = (count != '0);
  assign stat.oldest  = marks[0];

  always_comb begin
    marks_next = marks;
    count_next = count;
    if (ctrl.append && (count != CMAX)) begin
      for (int i = 0; i < MW; i++) begin
        if (CW'(i) == count) begin
          marks_next[i] = ctrl.keep;
        end
      end
      count_next = count + CW'(1);
    end else if (ctrl.consume && stat.pending) begin
      marks_next = marks >> 1;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
      count <= '0;
    end else begin
      marks <= marks_next;
      count <= count_next;
    end
  end

endmodule

FILE: sv/spi_slave_queued_exchange.sv
// ---------------------------------------------------------------------------
// spi_slave_queued_exchange
// Buffering for an SPI slave: reply queue, receive queue, keep/drop marks
// and the shift register load decision.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | into      | in_valid/in_stall | action tx_byte keep_reply
//          |           |                   | master_byte
//  out     | out of    | out_valid/out_stall | status read_byte load_valid
//          |           |                   | load_byte rx_overflow
//
//  One item per cycle sustained while out_stall is low. An item passes through
//  the input register, and its result is then written to the result register.
//  Reset (rst, synchronous) empties both queues and the mark queue and frees
//  the shift register; queue storage itself is not cleared.
//  A stalled result holds the result register; the input register then holds
//  too and in_stall rises. An unused action code yields no result.
//
module spi_slave_queued_exchange
  import ssqe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] tx_byte,
  input  logic       keep_reply,
  input  logic [7:0] master_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] read_byte,
  output logic       load_valid,
  output logic [7:0] load_byte,
  output logic       rx_overflow
);

  // input register
  logic       s1_valid;
  logic [1:0] s1_action;
  logic [7:0] s1_tx_byte;
  logic       s1_keep;
  logic [7:0] s1_master;

  // shift register occupancy
  logic shifter_free;
  logic shifter_free_next;

  // queue interfaces
  fifo_ctrl_t tx_ctrl;
  fifo_stat_t tx_stat;
  logic [7:0] tx_head;
  fifo_ctrl_t rx_ctrl;
  fifo_stat_t rx_stat;
  logic [7:0] rx_head;
  mark_ctrl_t mk_ctrl;
  mark_stat_t mk_stat;

  // result values computed this cycle
  logic       out_ready;
  logic       fire;
  logic       res_valid;
  logic [1:0] res_status;
  logic [7:0] res_read;
  logic       res_lv;
  logic [7:0] res_lb;
  logic       res_ovf;
  logic       store;

  // result register free, or being taken this cycle
  assign out_ready = !out_valid || !out_stall;
  assign fire      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action  <= action;
      s1_tx_byte <= tx_byte;
      s1_keep    <= keep_reply;
      s1_master  <= master_byte;
    end
  end

  // single-pass item decode and queue control
  always_comb begin
    tx_ctrl           = '0;
    rx_ctrl           = '0;
    mk_ctrl           = '0;
    mk_ctrl.keep      = s1_keep;
    shifter_free_next = shifter_free;
    res_valid         = 1'b0;
    res_status        = ST_OK;
    res_read          = '0;
    res_lv            = 1'b0;
    res_lb            = '0;
    res_ovf           = 1'b0;
    store             = 1'b1;
    if (fire) begin
      unique case (s1_action)
        ACT_QUEUE: begin
          res_valid = 1'b1;
          if (tx_stat.full) begin
            res_status = ST_TX_FULL;
          end else begin
            mk_ctrl.append = 1'b1;
            // nothing ahead of it: straight into the shift register
            if (tx_stat.empty && shifter_free) begin
              shifter_free_next = 1'b0;
              res_lv            = 1'b1;
              res_lb            = s1_tx_byte;
            end else begin
              tx_ctrl.push = 1'b1;
            end
          end
        end
        ACT_READ: begin
          res_valid = 1'b1;
          if (rx_stat.empty) begin
            res_status = ST_RX_EMPTY;
          end else begin
            res_read    = rx_head;
            rx_ctrl.pop = 1'b1;
          end
        end
        ACT_EXCH: begin
          res_valid  = 1'b1;
          res_status = ST_EXCH;
          // oldest mark decides; with no mark the byte is always kept
          if (mk_stat.pending) begin
            store           = mk_stat.oldest;
            mk_ctrl.consume = 1'b1;
          end
          if (store) begin
            if (rx_stat.full) begin
              res_ovf = 1'b1;
            end else begin
              rx_ctrl.push = 1'b1;
            end
          end
          if (!tx_stat.empty) begin
            res_lv            = 1'b1;
            res_lb            = tx_head;
            tx_ctrl.pop       = 1'b1;
            shifter_free_next = 1'b0;
          end else begin
            shifter_free_next = 1'b1;
          end
        end
        ACT_NONE: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shifter_free <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      shifter_free <= shifter_free_next;
      if (out_ready) begin
        out_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res_valid) begin
      status      <= res_status;
      read_byte   <= res_read;
      load_valid  <= res_lv;
      load_byte   <= res_lb;
      rx_overflow <= res_ovf;
    end
  end

  ssqe_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tx_ctrl),
    .wdata(s1_tx_byte),
    .head (tx_head),
    .stat (tx_stat)
  );

  ssqe_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rx_ctrl),
    .wdata(s1_master),
    .head (rx_head),
    .stat (rx_stat)
  );

  ssqe_marks #(
    .DEPTH(QUEUE_DEPTH)
  ) u_marks (
    .clk (clk),
    .rst (rst),
    .ctrl(mk_ctrl),
    .stat(mk_stat)
  );

endmodule
